// ===== rtl/core/gpr_pkg.sv =====
// shared types, constants and helpers for the glyph pixel renderer
`default_nettype none

package gpr_pkg;

	// font store geometry
	localparam int FONT_BYTES = 2048;
	localparam int FONT_AW    = $clog2(FONT_BYTES);
	localparam int GLYPH_ROWS = 16;
	localparam int ROW_W      = $clog2(GLYPH_ROWS);

	// field widths
	localparam int ADDR_W  = 32;
	localparam int COORD_W = 16;
	localparam int CODE_W  = 7;
	localparam int COLOR_W = 32;
	localparam int INDEX_W = 11;
	localparam int BPP_W   = 6;
	localparam int LINE_W  = COORD_W + ROW_W;
	localparam int PROD_W  = COORD_W + LINE_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

	// item kinds
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_DRAW  = 2'd2;

	// operands of the shared multiply-add unit: acc + a * b
	typedef struct packed {
		logic [ADDR_W-1:0]  acc;
		logic [COORD_W-1:0] a;
		logic [LINE_W-1:0]  b;
	} mac_op_t;

	// colour mask for a depth, zero for an unsupported one
	function automatic logic [COLOR_W-1:0] depth_mask(input logic [BPP_W-1:0] bpp);
		logic [COLOR_W-1:0] m;
		case (bpp)
			6'd8:    m = 32'h0000_00ff;
			6'd16:   m = 32'h0000_ffff;
			6'd24:   m = 32'h00ff_ffff;
			6'd32:   m = 32'hffff_ffff;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpr_font_mem.sv =====
// glyph row store, one write port and one registered read port
`default_nettype none

module gpr_font_mem
	import gpr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [FONT_AW-1:0] wr_addr,
	input  wire logic [7:0]         wr_data,
	input  wire logic [FONT_AW-1:0] rd_addr,
	output logic      [7:0]         rd_data
);

	logic [7:0] mem_q [FONT_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/gpr_mac.sv =====
// shared multiply-add unit used for every address step
`default_nettype none

module gpr_mac
	import gpr_pkg::*;
(
	input  wire mac_op_t           op,
	output logic      [ADDR_W-1:0] sum
);

	logic [PROD_W-1:0] prod;

	always_comb begin
		prod = PROD_W'(op.a) * PROD_W'(op.b);
		// addresses wrap at 32 bits
		sum  = op.acc + prod[ADDR_W-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/core/glyph_pixel_renderer.sv =====
// top level: config registers, sequencer, font store and output register
// sequence: a draw or set-pixel item sets up its address in ST_MUL_Y and ST_MUL_X, then
//   ST_ROW gives one row beat per cycle while the output slot is free; loads finish at once
// throughput: one item at a time; the input is ready again once an item's last beat is in
//   the output register, and stays ready after a load or an item that writes nothing
// reset (arst_n low, asynchronous): config registers to their defaults, sequencer idle,
//   output empty; the font store keeps whatever it held and must be loaded before use
`default_nettype none

module glyph_pixel_renderer
	import gpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// configuration writes
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
	input  wire logic [31:0]          cfg_wr_data,

	// input items
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// x_pos[15:0], y_pos[31:16], char_code[38:32], color[70:39],
	// font_index[81:71], font_byte[89:82], zero fill[95:90]
	input  wire logic [95:0]          s_axis_tdata,
	// op[1:0]
	input  wire logic [1:0]           s_axis_tuser,

	// frame buffer writes
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// write_address[31:0], pixel_mask[39:32], pixel_value[71:40]
	output logic [71:0]               m_axis_tdata,
	output logic                      m_axis_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL_Y = 4'b0010,
		ST_MUL_X = 4'b0100,
		ST_ROW   = 4'b1000
	} state_t;

	// configuration registers
	logic [ADDR_W-1:0]  base_q;
	logic [COORD_W-1:0] pitch_q;
	logic [BPP_W-1:0]   bpp_q;
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;

	// unpacked input beat
	logic [1:0]         in_op;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [CODE_W-1:0]  in_code;
	logic [COLOR_W-1:0] in_color;
	logic [INDEX_W-1:0] in_index;
	logic [7:0]         in_byte;

	// item registers
	state_t             state_q;
	logic               draw_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [CODE_W-1:0]  code_q;
	logic [COLOR_W-1:0] value_q;
	logic [ADDR_W-1:0]  acc_q;
	logic [ROW_W-1:0]   row_q;

	// next code and row, used to address the registered font store ahead of the current row
	logic [CODE_W-1:0]  code_d;
	logic [ROW_W-1:0]   row_d;

	logic               in_beat;
	logic               depth_ok;
	logic               on_screen;
	logic               start;
	logic               slot_free;
	logic               row_last;
	logic               emit;

	mac_op_t            mac_op;
	logic [ADDR_W-1:0]  mac_sum;

	logic               font_we;
	logic [FONT_AW-1:0] font_rd_addr;
	logic [7:0]         glyph_byte;

	// output register payload
	logic [ADDR_W-1:0]  out_addr_q;
	logic [7:0]         out_mask_q;
	logic [COLOR_W-1:0] out_value_q;
	logic               out_last_q;

	assign in_op    = s_axis_tuser;
	assign in_x     = s_axis_tdata[15:0];
	assign in_y     = s_axis_tdata[31:16];
	assign in_code  = s_axis_tdata[38:32];
	assign in_color = s_axis_tdata[70:39];
	assign in_index = s_axis_tdata[81:71];
	assign in_byte  = s_axis_tdata[89:82];

	// configuration port, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			pitch_q  <= '0;
			bpp_q    <= BPP_W'(32);
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_wr_index)
				CFG_BASE:   base_q   <= cfg_wr_data;
				CFG_PITCH:  pitch_q  <= cfg_wr_data[COORD_W-1:0];
				CFG_BPP:    bpp_q    <= cfg_wr_data[BPP_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_wr_data[COORD_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wr_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// accept decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign depth_ok      = (depth_mask(bpp_q) != '0);
	assign on_screen     = (in_x < width_q) && (in_y < height_q);
	// loads, unused op codes, bad depths and off-screen pixels finish at once
	assign start         = in_beat && depth_ok &&
	                       ((in_op == OP_DRAW) || ((in_op == OP_PIXEL) && on_screen));

	// font loads write straight into the store on the accepting beat
	assign font_we = in_beat && (in_op == OP_LOAD) && (32'(in_index) < FONT_BYTES);

	// output slot handshake
	assign slot_free = !m_axis_tvalid || m_axis_tready;
	assign row_last  = !draw_q || (row_q == ROW_W'(GLYPH_ROWS - 1));
	assign emit      = (state_q == ST_ROW) && slot_free;

	// operand selection for the shared unit
	always_comb begin
		mac_op = '{acc: acc_q, a: pitch_q, b: LINE_W'(1)};
		case (state_q)
			ST_MUL_Y: begin
				// base + pitch * scan line of the first row
				mac_op.acc = base_q;
				mac_op.a   = pitch_q;
				mac_op.b   = draw_q ? LINE_W'(y_q) * LINE_W'(GLYPH_ROWS) : LINE_W'(y_q);
			end
			ST_MUL_X: begin
				// + column offset: a character cell is eight pixels wide
				mac_op.a = x_q;
				mac_op.b = draw_q ? LINE_W'({bpp_q[BPP_W-1:3], 3'b000})
				                  : LINE_W'(bpp_q[BPP_W-1:3]);
			end
			default: ;
		endcase
	end

	gpr_mac u_mac (
		.op  (mac_op),
		.sum (mac_sum)
	);

	// font store is read at the row that will be current next cycle
	always_comb begin
		code_d = in_beat ? in_code : code_q;
		row_d  = row_q;
		if (state_q == ST_IDLE) begin
			row_d = '0;
		end else if (emit && !row_last) begin
			row_d = row_q + ROW_W'(1);
		end
		font_rd_addr = FONT_AW'(32'(code_d) * GLYPH_ROWS + 32'(row_d));
	end

	gpr_font_mem u_font (
		.clk     (clk),
		.wr_en   (font_we),
		.wr_addr (in_index[FONT_AW-1:0]),
		.wr_data (in_byte),
		.rd_addr (font_rd_addr),
		.rd_data (glyph_byte)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			row_q <= row_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL_Y;
					end
				end
				ST_MUL_Y: state_q <= ST_MUL_X;
				ST_MUL_X: state_q <= ST_ROW;
				ST_ROW: begin
					if (emit && row_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and running address
	always_ff @(posedge clk) begin
		if (in_beat) begin
			draw_q  <= (in_op == OP_DRAW);
			x_q     <= in_x;
			y_q     <= in_y;
			code_q  <= in_code;
			value_q <= in_color & depth_mask(bpp_q);
		end
		// address set-up in ST_MUL_Y and ST_MUL_X, then a step to the next scan line after each row beat
		if (state_q == ST_MUL_Y || state_q == ST_MUL_X || emit) begin
			acc_q <= mac_sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q  <= acc_q;
			out_mask_q  <= draw_q ? glyph_byte : 8'h01;
			out_value_q <= value_q;
			out_last_q  <= row_last;
		end
	end

	assign m_axis_tdata = {out_value_q, out_mask_q, out_addr_q};
	assign m_axis_tlast = out_last_q;

endmodule

`default_nettype wire

// ===== test/gpr_write_checker.sv =====
// frame buffer write predictor and beat checker for the glyph pixel renderer
module gpr_write_checker
	import gpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_wr_index,
	input  logic [31:0]          cfg_wr_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	// x_pos, y_pos, char_code, color, font_index, font_byte, zero fill
	input  logic [95:0]          s_axis_tdata,
	// op
	input  logic [1:0]           s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// write_address, pixel_mask, pixel_value
	input  logic [71:0]          m_axis_tdata,
	input  logic                 m_axis_tlast,
	output int                   fail_count,
	output int                   writes_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         mask;
		logic [COLOR_W-1:0] value;
		logic               last;
	} fb_write_t;

	fb_write_t expected_writes[$];

	// own copy of the font store and the registers
	logic [7:0]         glyph_rows [FONT_BYTES];
	logic [ADDR_W-1:0]  base_addr;
	logic [15:0]        pitch;
	logic [BPP_W-1:0]   bpp;
	logic [15:0]        width;
	logic [15:0]        height;

	task automatic predict_writes(input logic [1:0] op, input logic [95:0] beat);
		logic [15:0]        x;
		logic [15:0]        y;
		logic [6:0]         code;
		logic [COLOR_W-1:0] colour;
		logic [10:0]        fidx;
		logic [7:0]         fbyte;
		logic               depth_ok;
		logic [31:0]        bytes;
		logic [31:0]        line;
		fb_write_t          w;
		x        = beat[15:0];
		y        = beat[31:16];
		code     = beat[38:32];
		colour   = beat[70:39];
		fidx     = beat[81:71];
		fbyte    = beat[89:82];
		depth_ok = (bpp == 6'd8) || (bpp == 6'd16) || (bpp == 6'd24) || (bpp == 6'd32);
		bytes    = 32'(bpp >> 3);
		w.value  = depth_ok ? (colour & (32'hffff_ffff >> (32 - int'(bpp)))) : '0;
		case (op)
			OP_LOAD: begin
				if (int'(fidx) < FONT_BYTES)
					glyph_rows[fidx] = fbyte;
			end
			OP_PIXEL: begin
				if (depth_ok && x < width && y < height) begin
					w.addr = base_addr + 32'(y) * 32'(pitch) + 32'(x) * bytes;
					w.mask = 8'd1;
					w.last = 1'b1;
					expected_writes.push_back(w);
				end
			end
			OP_DRAW: begin
				if (depth_ok) begin
					for (int r = 0; r < GLYPH_ROWS; r++) begin
						line   = 32'(y) * GLYPH_ROWS + r;
						w.addr = base_addr + line * 32'(pitch) + 32'(x) * 32'd8 * bytes;
						w.mask = glyph_rows[(int'(code) * GLYPH_ROWS + r) % FONT_BYTES];
						w.last = (r == GLYPH_ROWS - 1);
						expected_writes.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_write(input fb_write_t got);
		fb_write_t want;
		if (expected_writes.size() == 0) begin
			$display("%0t ns: unexpected write, address %h mask %h value %h last %b",
				$time, got.addr, got.mask, got.value, got.last);
			fail_count++;
			return;
		end
		want = expected_writes.pop_front();
		if (got.addr !== want.addr) begin
			$display("%0t ns: write_address expected %h, got %h", $time, want.addr, got.addr);
			fail_count++;
		end
		if (got.mask !== want.mask) begin
			$display("%0t ns: pixel_mask expected %h, got %h", $time, want.mask, got.mask);
			fail_count++;
		end
		if (got.value !== want.value) begin
			$display("%0t ns: pixel_value expected %h, got %h", $time, want.value, got.value);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$display("%0t ns: last expected %b, got %b", $time, want.last, got.last);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr = '0;
			pitch     = '0;
			bpp       = 6'd32;
			width     = '0;
			height    = '0;
			expected_writes.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_wr_index)
					CFG_BASE:   base_addr = cfg_wr_data;
					CFG_PITCH:  pitch     = cfg_wr_data[15:0];
					CFG_BPP:    bpp       = cfg_wr_data[BPP_W-1:0];
					CFG_WIDTH:  width     = cfg_wr_data[15:0];
					CFG_HEIGHT: height    = cfg_wr_data[15:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_writes(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_write({m_axis_tdata[31:0], m_axis_tdata[39:32], m_axis_tdata[71:40],
					m_axis_tlast});
		end
		writes_pending = expected_writes.size();
	end

endmodule

// ===== test/tb.sv =====
// testbench top for the glyph pixel renderer: clock, reset, stimulus and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gpr_pkg::*;

	localparam int         ITEM_TARGET      = 420;
	localparam int         SINK_HOLD_CYCLES = 400;
	// settle time after the last predicted write, covering anything still in flight
	localparam int         SETTLE_CYCLES    = 32;
	localparam int         TIMEOUT_NS       = 36_000_000;
	// opcode the block has no use for
	localparam logic [1:0] OP_UNUSED        = 2'd3;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_wr_index   = CFG_BASE;
	logic [31:0]          cfg_wr_data    = '0;
	logic                 s_axis_tvalid  = 1'b0;
	logic                 s_axis_tready;
	// x_pos[15:0], y_pos[31:16], char_code[38:32], color[70:39],
	// font_index[81:71], font_byte[89:82], zero fill[95:90]
	logic [95:0]          s_axis_tdata   = '0;
	// op[1:0]
	logic [1:0]           s_axis_tuser   = OP_LOAD;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready  = 1'b0;
	// write_address[31:0], pixel_mask[39:32], pixel_value[71:40]
	logic [71:0]          m_axis_tdata;
	logic                 m_axis_tlast;

	int fail_count;
	int writes_pending;

	glyph_pixel_renderer uut (.*);

	gpr_write_checker write_check (.*);

	// font bytes loaded so far; a glyph may only be drawn once all its rows are in
	logic       byte_loaded [FONT_BYTES] = '{default: 1'b0};
	bit         glyph_listed [128];
	logic [6:0] ready_glyphs[$];

	// what the block is set to at the moment, for aiming the stimulus
	logic [15:0]      cur_width  = '0;
	logic [15:0]      cur_height = '0;

	int items_counted;
	int tx_free_left;
	bit sink_hold_req;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case the handshakes lock up
	initial begin
		#TIMEOUT_NS;
		$display("FAILURE");
		$finish;
	end

	// idle length on either side: mostly none or short, now and then long
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// set-pixel coordinate: mostly on screen, sometimes right on the bound, sometimes anywhere
	function automatic logic [15:0] pixel_coord(input logic [15:0] extent);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return (extent == 0) ? 16'd0 : 16'($urandom_range(0, extent - 1));
		if (pick < 17)
			return extent;
		return 16'($urandom);
	endfunction

	// screen size for a random setting, including zero and the full range
	function automatic logic [15:0] screen_extent();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 16'd0;
		if (pick == 1)
			return 16'hffff;
		if (pick < 5)
			return 16'($urandom);
		return 16'($urandom_range(1, 64));
	endfunction

	// called at a falling edge; returns at a falling edge after the beat and any gap
	task automatic send_item(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
			input logic [6:0] code, input logic [31:0] colour, input logic [10:0] fidx,
			input logic [7:0] fbyte);
		int         gap;
		logic [6:0] gcode;
		bit         complete;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {6'd0, fbyte, fidx, colour, code, y, x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_counted++;
		if (op == OP_LOAD) begin
			byte_loaded[fidx] = 1'b1;
			gcode = fidx[10:4];
			complete = 1'b1;
			for (int r = 0; r < GLYPH_ROWS; r++)
				complete &= byte_loaded[{gcode, 4'(r)}];
			if (complete && !glyph_listed[gcode]) begin
				glyph_listed[gcode] = 1'b1;
				ready_glyphs.push_back(gcode);
			end
		end
		// now and then a burst with no gaps at all
		if (tx_free_left > 0) begin
			tx_free_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 24) == 0)
				tx_free_left = $urandom_range(20, 60);
			gap = idle_len();
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// writes every register once; upper bits beyond a register's width carry junk
	task automatic configure(input logic [31:0] base, input logic [15:0] pitch,
			input logic [BPP_W-1:0] bpp, input logic [15:0] width, input logic [15:0] height);
		logic [CFG_IDX_W-1:0] regs [5];
		logic [31:0]          value [5];
		int                   bits [5];
		regs  = '{CFG_BASE, CFG_PITCH, CFG_BPP, CFG_WIDTH, CFG_HEIGHT};
		value = '{base, 32'(pitch), 32'(bpp), 32'(width), 32'(height)};
		bits  = '{32, 16, BPP_W, 16, 16};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en    <= 1'b1;
			cfg_wr_index <= regs[i];
			cfg_wr_data  <= value[i] | ((bits[i] < 32) ? ($urandom << bits[i]) : 32'd0);
			@(negedge clk);
		end
		cfg_wr_en  <= 1'b0;
		cur_width  = width;
		cur_height = height;
	endtask

	// sender holds back until every predicted write is out and the block has gone quiet
	task automatic drain_writes();
		s_axis_tvalid <= 1'b0;
		while (writes_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sixteen row loads; fixed_rows forces empty, full and single-pixel rows at the top
	task automatic load_glyph(input logic [6:0] code, input bit fixed_rows);
		logic [7:0] row_bits;
		int         sel;
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			sel = (fixed_rows && r < 4) ? r : $urandom_range(0, 11);
			case (sel)
				0:       row_bits = 8'h00;
				1:       row_bits = 8'hff;
				2:       row_bits = 8'h01;
				3:       row_bits = 8'h80;
				default: row_bits = 8'($urandom);
			endcase
			send_item(OP_LOAD, 16'($urandom), 16'($urandom), 7'($urandom), $urandom,
				11'(int'(code) * GLYPH_ROWS + r), row_bits);
		end
	endtask

	// draw a glyph, loading it first if its rows are not all in the store yet
	task automatic draw_glyph(input bit prefer_loaded);
		logic [6:0]  code;
		logic [15:0] x;
		logic [15:0] y;
		if (prefer_loaded && ready_glyphs.size() > 0)
			code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
		else
			code = 7'($urandom);
		if (!glyph_listed[code])
			load_glyph(code, 1'b0);
		x = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		y = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		send_item(OP_DRAW, x, y, code, $urandom, 11'($urandom), 8'($urandom));
	endtask

	// receiver: random stalls, stretches always ready, and one long hold on request
	initial begin : frame_buffer_sink
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				// long hold-off, counted here, so the block backs up into its input
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (free_left == 0 && $urandom_range(0, 19) == 0)
					free_left = $urandom_range(50, 200);
				if (free_left > 0) begin
					free_left--;
					m_axis_tready <= 1'b1;
				end else begin
					stall_left = idle_len();
					m_axis_tready <= (stall_left == 0);
					if (stall_left > 0)
						stall_left--;
				end
			end
		end
	end

	initial begin : stimulus
		int               phase_no;
		int               phase_end;
		int               tries;
		int               pick;
		logic [BPP_W-1:0] depth;

		// reset held low from the start, released on a falling edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: addresses that wrap, full-range coordinates, all four bounds cases
		configure(32'hffff_fff0, 16'hffff, 6'd32, 16'hffff, 16'hffff);
		load_glyph(7'h7f, 1'b1);
		send_item(OP_DRAW, 16'hffff, 16'hffff, 7'h7f, 32'hffff_ffff, 11'h7ff, 8'hff);
		send_item(OP_DRAW, 16'h0000, 16'h0000, 7'h7f, 32'h0000_0000, 11'h000, 8'h00);
		send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 7'($urandom), $urandom,
			11'($urandom), 8'($urandom));
		send_item(OP_PIXEL, 16'h0000, 16'h0000, 7'h00, $urandom, 11'h000, 8'h00);
		send_item(OP_PIXEL, 16'hfffe, 16'hfffe, 7'h7f, $urandom, 11'h7ff, 8'hff);
		// just off the right edge, then just off the bottom
		send_item(OP_PIXEL, 16'hffff, 16'h0000, 7'h00, $urandom, 11'h000, 8'h00);
		send_item(OP_PIXEL, 16'h0000, 16'hffff, 7'h00, $urandom, 11'h000, 8'h00);
		drain_writes();

		// a depth the block does not support: draws and pixels write nothing
		configure($urandom, 16'($urandom), 6'd12, 16'hffff, 16'hffff);
		send_item(OP_DRAW, 16'd1, 16'd1, 7'h7f, $urandom, 11'h000, 8'h00);
		send_item(OP_PIXEL, 16'd1, 16'd1, 7'h00, $urandom, 11'h000, 8'h00);
		drain_writes();

		// random phases, each under its own setting, written while the block is idle
		phase_no = 0;
		while (items_counted < ITEM_TARGET) begin
			case (phase_no)
				0: configure(32'hffff_ffff, 16'hffff, 6'd24, 16'hffff, 16'hffff);
				1: configure(32'h0000_0000, 16'h0000, 6'd8, 16'h0000, 16'h0000);
				default: begin
					if (phase_no == 2 || $urandom_range(0, 6) != 0) begin
						case ($urandom_range(0, 3))
							0:       depth = 6'd8;
							1:       depth = 6'd16;
							2:       depth = 6'd24;
							default: depth = 6'd32;
						endcase
					end else begin
						case ($urandom_range(0, 3))
							0:       depth = 6'd0;
							1:       depth = 6'd7;
							2:       depth = 6'd12;
							default: depth = 6'd31;
						endcase
					end
					configure(($urandom_range(0, 4) == 0) ? {32{1'($urandom)}} : $urandom,
						$urandom_range(0, 1) ? 16'($urandom_range(1, 4096)) : 16'($urandom),
						depth, screen_extent(), screen_extent());
				end
			endcase

			// sink stops for a long while as draws keep coming, so the input backs up
			if (phase_no == 2) begin
				sink_hold_req = 1'b1;
				repeat (8) draw_glyph(1'b1);
			end

			phase_end = items_counted + $urandom_range(25, 60);
			tries = 0;
			while (items_counted < phase_end && items_counted < ITEM_TARGET && tries < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					draw_glyph($urandom_range(0, 9) < 7);
				else if (pick < 68)
					send_item(OP_PIXEL, pixel_coord(cur_width), pixel_coord(cur_height),
						7'($urandom), $urandom, 11'($urandom), 8'($urandom));
				else if (pick < 80)
					// stray load anywhere in the store, possibly over a glyph in use
					send_item(OP_LOAD, 16'($urandom), 16'($urandom), 7'($urandom), $urandom,
						11'($urandom), 8'($urandom));
				else if (pick < 85)
					send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 7'($urandom), $urandom,
						11'($urandom), 8'($urandom));
				else if (pick < 90)
					drain_writes();
				else
					repeat (4) draw_glyph(1'b1);
				tries++;
			end
			drain_writes();
			phase_no++;
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/gpr_pkg.sv
rtl/core/gpr_font_mem.sv
rtl/core/gpr_mac.sv
rtl/core/glyph_pixel_renderer.sv
test/gpr_write_checker.sv
test/tb.sv
